@@ hdl/i2cmts_pkg.sv @@
// shared types, request codes and beat layouts of the i2c master transaction sequencer
package i2cmts_pkg;

   // sequencer phases
   typedef enum logic [4:0] {
      PH_IDLE    = 5'd0,
      PH_START_W = 5'd1,
      PH_START_R = 5'd2,
      PH_ADDRW   = 5'd3,
      PH_WORD    = 5'd4,
      PH_DATA    = 5'd5,
      PH_ADDRR   = 5'd6,
      PH_RX_PRE  = 5'd7,
      PH_RX_WAIT = 5'd8,
      PH_RX_POST = 5'd9,
      PH_RX_BITS = 5'd10,
      PH_MACK    = 5'd11,
      PH_MNACK   = 5'd12,
      PH_STOP    = 5'd13
   } phase_type;

   // request kinds carried on req_tuser
   localparam logic [2:0] REQ_NONE       = 3'd0;
   localparam logic [2:0] REQ_COMMAND    = 3'd1;
   localparam logic [2:0] REQ_WRITE_BYTE = 3'd2;
   localparam logic [2:0] REQ_WRITE_BLK  = 3'd3;
   localparam logic [2:0] REQ_READ_BYTE  = 3'd4;
   localparam logic [2:0] REQ_READ_BLK   = 3'd5;
   localparam logic [2:0] REQ_READ_CUR   = 3'd6;

   localparam int TIMEOUT_W       = 20;
   localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 20'd333333;

   // request tdata layout
   localparam int REQ_TDATA_W     = 40;
   localparam int REQ_DEV_LSB     = 0;
   localparam int REQ_WORD_LSB    = 7;
   localparam int REQ_TX_LSB      = 15;
   localparam int REQ_LEN_LSB     = 23;
   localparam int REQ_STRETCH_BIT = 31;
   localparam int REQ_SDA_BIT     = 32;
   localparam int REQ_SCL_BIT     = 33;

   // response tdata layout
   localparam int RSP_TDATA_W     = 16;
   localparam int RSP_SCL_BIT     = 0;
   localparam int RSP_SDA_BIT     = 1;
   localparam int RSP_BUSY_BIT    = 2;
   localparam int RSP_RXB_LSB     = 3;
   localparam int RSP_RXV_BIT     = 11;
   localparam int RSP_TAKEN_BIT   = 12;
   localparam int RSP_DONE_BIT    = 13;

endpackage

@@ hdl/i2c_master_transaction_sequencer.sv @@
// top level of the i2c master transaction sequencer
//
// usage: every request beat is one 3 us bus tick. req_tuser carries the request
// kind (ignored unless the sequencer is idle), req_tdata the transaction fields
// and the sampled sda/scl levels. each accepted request beat yields exactly one
// response beat with the two open-drain pin drives, busy, received byte with its
// valid mark (rsp_tlast marks the final byte of a read), tx_taken and done.
// csr_* writes the 20-bit clock stretch timeout, always ready; the user must
// write it only while idle, which the block itself does not enforce.
// the response register holds the result of the last accepted tick. throughput:
// one tick per cycle while responses are taken, set by the single pass of the
// phase logic from the state registers into the response register. the next tick
// is accepted while a finished response is being taken.
//
// reset: phase idle, lines released, counters cleared, timeout 333333,
// response channel empty.
// stall: when rsp_tready is low with a response pending, req_tready drops and
// the sequencer state is frozen until the response beat is taken.
module i2c_master_transaction_sequencer
   import i2cmts_pkg::*;
#(
   parameter int STRETCH_COUNT_BITS = 20
) (
   input  logic                      clock,
   input  logic                      reset,
   // request channel
   input  logic                      req_tvalid,
   output logic                      req_tready,
   // dev_addr[6:0], word_addr[14:7], tx_byte[22:15], length[30:23],
   // stretch_enable[31], sda_in[32], scl_in[33], zero pad[39:34]
   input  logic [REQ_TDATA_W-1:0]    req_tdata,
   // req_type[2:0]
   input  logic [2:0]                req_tuser,
   // response channel
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   // scl_release[0], sda_release[1], busy_res[2], rx_byte[10:3], rx_valid[11],
   // tx_taken[12], done_res[13], zero pad[15:14]
   output logic [RSP_TDATA_W-1:0]    rsp_tdata,
   // rx_last
   output logic                      rsp_tlast,
   // stretch timeout register write
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [TIMEOUT_W-1:0]      csr_data
);

   localparam int CMP_W = (STRETCH_COUNT_BITS > TIMEOUT_W) ? STRETCH_COUNT_BITS : TIMEOUT_W;

   // sequencer state
   phase_type                     phase_ff, phase_in;
   logic [2:0]                    tick_ff, tick_in;
   logic [3:0]                    bit_count_ff, bit_count_in;
   logic [7:0]                    shift_ff, shift_in;
   logic [7:0]                    byte_count_ff, byte_count_in;
   logic [2:0]                    held_kind_ff, held_kind_in;
   logic [6:0]                    held_dev_ff, held_dev_in;
   logic [7:0]                    held_word_ff, held_word_in;
   logic [7:0]                    held_length_ff, held_length_in;
   logic                          held_stretch_ff, held_stretch_in;
   logic [STRETCH_COUNT_BITS-1:0] stretch_count_ff, stretch_count_in;
   logic [1:0]                    pin_drive_ff, pin_drive_in;
   logic [TIMEOUT_W-1:0]          timeout_ff;

   // response register
   logic                          rsp_valid_ff;
   logic [RSP_TDATA_W-1:0]        rsp_data_ff, rsp_data_in;
   logic                          rsp_last_ff, rsp_last_in;

   logic req_fire;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_fire   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

   // one tick of the bus sequencer
   always_comb begin
      logic       scl, sda, busy, rxv, rxl, taken, done;
      logic [7:0] rxb;
      logic [7:0] rlen;
      logic [2:0] t;
      logic       sda_in, scl_in;

      sda_in = req_tdata[REQ_SDA_BIT];
      scl_in = req_tdata[REQ_SCL_BIT];

      phase_in         = phase_ff;
      tick_in          = tick_ff;
      bit_count_in     = bit_count_ff;
      shift_in         = shift_ff;
      byte_count_in    = byte_count_ff;
      held_kind_in     = held_kind_ff;
      held_dev_in      = held_dev_ff;
      held_word_in     = held_word_ff;
      held_length_in   = held_length_ff;
      held_stretch_in  = held_stretch_ff;
      stretch_count_in = stretch_count_ff;

      scl   = 1'b1;
      sda   = 1'b1;
      busy  = 1'b0;
      rxv   = 1'b0;
      rxl   = 1'b0;
      rxb   = 8'd0;
      taken = 1'b0;
      done  = 1'b0;

      // new transaction, only taken while idle
      if (phase_ff == PH_IDLE && req_tuser >= REQ_COMMAND && req_tuser <= REQ_READ_CUR) begin
         held_kind_in    = req_tuser;
         held_dev_in     = req_tdata[REQ_DEV_LSB +: 7];
         held_word_in    = req_tdata[REQ_WORD_LSB +: 8];
         held_length_in  = req_tdata[REQ_LEN_LSB +: 8];
         held_stretch_in = (req_tuser == REQ_READ_CUR) && req_tdata[REQ_STRETCH_BIT];
         byte_count_in   = 8'd0;
         phase_in        = (req_tuser == REQ_READ_CUR) ? PH_START_R : PH_START_W;
         tick_in         = 3'd0;
         bit_count_in    = 4'd0;
      end

      t    = tick_in;
      busy = (phase_in != PH_IDLE);
      rlen = (held_kind_in == REQ_READ_BYTE || held_length_in == 8'd0) ? 8'd1 : held_length_in;

      case (phase_in)
         PH_START_W, PH_START_R: begin
            if (t < 3'd2) begin
               scl = pin_drive_ff[1];
               sda = 1'b1;
            end else if (t < 3'd4) begin
               scl = 1'b1;
               sda = 1'b1;
            end else if (t < 3'd6) begin
               scl = 1'b1;
               sda = 1'b0;
            end else begin
               scl = 1'b0;
               sda = 1'b0;
            end
            if (t == 3'd7) begin
               phase_in     = (phase_in == PH_START_W) ? PH_ADDRW : PH_ADDRR;
               tick_in      = 3'd0;
               bit_count_in = 4'd0;
            end else begin
               tick_in = t + 3'd1;
            end
         end
         PH_ADDRW, PH_WORD, PH_DATA, PH_ADDRR: begin
            if (bit_count_in < 4'd8) begin
               // load the byte on the first tick of its first bit
               if (bit_count_in == 4'd0 && t == 3'd0) begin
                  case (phase_in)
                     PH_ADDRW: shift_in = {held_dev_in, 1'b0};
                     PH_WORD:  shift_in = held_word_in;
                     PH_DATA: begin
                        shift_in = req_tdata[REQ_TX_LSB +: 8];
                        taken    = 1'b1;
                     end
                     default:  shift_in = {held_dev_in, 1'b1};
                  endcase
               end
               sda = shift_in[7];
               scl = (t == 3'd1 || t == 3'd2);
               if (t >= 3'd3) begin
                  shift_in     = {shift_in[6:0], 1'b0};
                  tick_in      = 3'd0;
                  bit_count_in = bit_count_in + 4'd1;
               end else begin
                  tick_in = t + 3'd1;
               end
            end else begin
               // tail tick, then the unchecked slave acknowledge
               if (t == 3'd0) begin
                  scl = 1'b0;
                  sda = pin_drive_ff[0];
               end else begin
                  sda = 1'b1;
                  scl = (t == 3'd3 || t == 3'd4);
               end
               if (t >= 3'd6) begin
                  tick_in      = 3'd0;
                  bit_count_in = 4'd0;
                  case (phase_in)
                     PH_ADDRW:
                        phase_in = (held_kind_in == REQ_COMMAND) ? PH_DATA : PH_WORD;
                     PH_WORD: begin
                        if (held_kind_in == REQ_WRITE_BYTE)
                           phase_in = PH_DATA;
                        else if (held_kind_in == REQ_WRITE_BLK)
                           phase_in = (held_length_in != 8'd0) ? PH_DATA : PH_STOP;
                        else
                           phase_in = PH_START_R;
                     end
                     PH_DATA: begin
                        if (held_kind_in == REQ_WRITE_BLK) begin
                           byte_count_in = byte_count_in + 8'd1;
                           phase_in = (byte_count_in < held_length_in) ? PH_DATA : PH_STOP;
                        end else begin
                           phase_in = PH_STOP;
                        end
                     end
                     default:
                        phase_in = held_stretch_in ? PH_RX_PRE : PH_RX_BITS;
                  endcase
               end else begin
                  tick_in = t + 3'd1;
               end
            end
         end
         PH_RX_PRE: begin
            if (t >= 3'd1) begin
               stretch_count_in = '0;
               phase_in         = PH_RX_WAIT;
               tick_in          = 3'd0;
               bit_count_in     = 4'd0;
            end else begin
               tick_in = t + 3'd1;
            end
         end
         PH_RX_WAIT: begin
            // wait for the slave to let scl go, or give up at the timeout
            if (scl_in || CMP_W'(stretch_count_in) >= CMP_W'(timeout_ff)) begin
               phase_in     = PH_RX_POST;
               tick_in      = 3'd0;
               bit_count_in = 4'd0;
            end else if (stretch_count_in != '1) begin
               stretch_count_in = stretch_count_in + 1'b1;
            end
         end
         PH_RX_POST: begin
            if (t >= 3'd1) begin
               phase_in     = PH_RX_BITS;
               tick_in      = 3'd0;
               bit_count_in = 4'd0;
            end else begin
               tick_in = t + 3'd1;
            end
         end
         PH_RX_BITS: begin
            scl = (t < 3'd2);
            if (t == 3'd1) begin
               shift_in = {shift_in[6:0], sda_in};
               if (bit_count_in >= 4'd7) begin
                  rxv = 1'b1;
                  rxb = shift_in;
                  rxl = ({1'b0, byte_count_in} + 9'd1) >= {1'b0, rlen};
               end
            end
            if (t >= 3'd3) begin
               if (bit_count_in >= 4'd7) begin
                  byte_count_in = byte_count_in + 8'd1;
                  phase_in      = (byte_count_in >= rlen) ? PH_MNACK : PH_MACK;
                  tick_in       = 3'd0;
                  bit_count_in  = 4'd0;
               end else begin
                  bit_count_in = bit_count_in + 4'd1;
                  tick_in      = 3'd0;
               end
            end else begin
               tick_in = t + 3'd1;
            end
         end
         PH_MACK: begin
            if (t < 3'd6) begin
               sda = 1'b0;
               scl = (t == 3'd2 || t == 3'd3);
            end else begin
               sda = 1'b1;
               scl = 1'b0;
            end
            if (t >= 3'd6) begin
               phase_in     = held_stretch_in ? PH_RX_PRE : PH_RX_BITS;
               tick_in      = 3'd0;
               bit_count_in = 4'd0;
            end else begin
               tick_in = t + 3'd1;
            end
         end
         PH_MNACK: begin
            sda = 1'b1;
            scl = (t == 3'd2 || t == 3'd3);
            if (t >= 3'd5) begin
               phase_in     = PH_STOP;
               tick_in      = 3'd0;
               bit_count_in = 4'd0;
            end else begin
               tick_in = t + 3'd1;
            end
         end
         PH_STOP: begin
            if (t < 3'd2) begin
               scl = 1'b0;
               sda = 1'b0;
            end else if (t < 3'd4) begin
               scl = 1'b1;
               sda = 1'b0;
            end else begin
               scl = 1'b1;
               sda = 1'b1;
            end
            if (t >= 3'd5) begin
               done         = 1'b1;
               phase_in     = PH_IDLE;
               tick_in      = 3'd0;
               bit_count_in = 4'd0;
            end else begin
               tick_in = t + 3'd1;
            end
         end
         default: begin
            // idle, or a code that means nothing: fall back to idle
            if (phase_in != PH_IDLE) begin
               phase_in     = PH_IDLE;
               tick_in      = 3'd0;
               bit_count_in = 4'd0;
            end
            busy = 1'b0;
         end
      endcase

      pin_drive_in = {scl, sda};

      rsp_data_in                      = '0;
      rsp_data_in[RSP_SCL_BIT]         = scl;
      rsp_data_in[RSP_SDA_BIT]         = sda;
      rsp_data_in[RSP_BUSY_BIT]        = busy;
      rsp_data_in[RSP_RXB_LSB +: 8]    = rxb;
      rsp_data_in[RSP_RXV_BIT]         = rxv;
      rsp_data_in[RSP_TAKEN_BIT]       = taken;
      rsp_data_in[RSP_DONE_BIT]        = done;
      rsp_last_in                      = rxl;
   end

   // state advances once per accepted tick
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff         <= PH_IDLE;
         tick_ff          <= '0;
         bit_count_ff     <= '0;
         shift_ff         <= '0;
         byte_count_ff    <= '0;
         held_kind_ff     <= '0;
         held_dev_ff      <= '0;
         held_word_ff     <= '0;
         held_length_ff   <= '0;
         held_stretch_ff  <= 1'b0;
         stretch_count_ff <= '0;
         pin_drive_ff     <= 2'b11;
      end else if (req_fire) begin
         phase_ff         <= phase_in;
         tick_ff          <= tick_in;
         bit_count_ff     <= bit_count_in;
         shift_ff         <= shift_in;
         byte_count_ff    <= byte_count_in;
         held_kind_ff     <= held_kind_in;
         held_dev_ff      <= held_dev_in;
         held_word_ff     <= held_word_in;
         held_length_ff   <= held_length_in;
         held_stretch_ff  <= held_stretch_in;
         stretch_count_ff <= stretch_count_in;
         pin_drive_ff     <= pin_drive_in;
      end
   end

   // stretch timeout register
   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff <= TIMEOUT_RESET;
      end else if (csr_valid && csr_ready) begin
         timeout_ff <= csr_data;
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         rsp_data_ff <= rsp_data_in;
         rsp_last_ff <= rsp_last_in;
      end
   end

endmodule

@@ hdl/i2cmts_checker.sv @@
// port-level checker for the i2c master transaction sequencer, with its bind
module i2cmts_checker
   import i2cmts_pkg::*;
(
   input logic                   clock,
   input logic                   reset,
   input logic                   rsp_tvalid,
   input logic                   rsp_tready,
   input logic [RSP_TDATA_W-1:0] rsp_tdata,
   input logic                   rsp_tlast
);

   // a held beat stays unchanged until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("response beat changed while stalled");

   // last mark only on a received byte
   a_last_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> rsp_tdata[RSP_RXV_BIT])
      else $error("rx_last without rx_valid");

   // stop completes with both lines released while still busy
   a_done_lines: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[RSP_DONE_BIT] |->
         rsp_tdata[RSP_BUSY_BIT] && rsp_tdata[RSP_SCL_BIT] && rsp_tdata[RSP_SDA_BIT])
      else $error("done without released lines");

   // idle ticks leave the bus alone and raise no flag
   a_idle_quiet: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[RSP_BUSY_BIT] |->
         rsp_tdata[RSP_SCL_BIT] && rsp_tdata[RSP_SDA_BIT] && !rsp_tdata[RSP_RXV_BIT]
         && !rsp_tdata[RSP_TAKEN_BIT] && !rsp_tdata[RSP_DONE_BIT])
      else $error("activity while idle");

endmodule

bind i2c_master_transaction_sequencer i2cmts_checker u_i2cmts_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);

@@ tb/tb.sv @@
// self-checking testbench for the i2c master transaction sequencer, predicted tick by tick
module tb;
   import i2cmts_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int COUNT_W = 20;
   // the request code above the last defined kind, ignored by the sequencer
   localparam logic [2:0] REQ_UNKNOWN = 3'd7;

   // one bus tick as offered on the request channel
   typedef struct packed {
      logic [2:0] kind;
      logic [6:0] dev;
      logic [7:0] word;
      logic [7:0] txb;
      logic [7:0] len;
      logic       stretch;
      logic       sda_in;
      logic       scl_in;
   } tick_req_type;

   // pin drives and flags of one tick
   typedef struct packed {
      logic       scl;
      logic       sda;
      logic       busy;
      logic [7:0] rx_byte;
      logic       rx_valid;
      logic       rx_last;
      logic       taken;
      logic       done;
   } tick_result_type;

   // one line of the directed script: a transaction, or a single idle tick
   typedef struct packed {
      logic [2:0]           kind;
      logic [6:0]           dev;
      logic [7:0]           word;
      logic [7:0]           txb;
      logic [7:0]           len;
      logic                 stretch;
      logic [7:0]           scl_low;     // ticks the slave holds scl low per read byte
      logic [TIMEOUT_W-1:0] timeout_wr;  // stretch timeout written first, 0 for none
      logic                 fixed_idle;  // result is the released idle tick
   } script_row_type;

   localparam tick_result_type IDLE_TICK = '{scl: 1'b1, sda: 1'b1, default: '0};

   localparam int SCRIPT_LEN = 18;
   localparam script_row_type SCRIPT [SCRIPT_LEN] = '{
      // idle straight after reset, then an unknown request code
      '{REQ_NONE,       7'h00, 8'h00, 8'h00, 8'h00, 1'b0, 8'd0,  20'd0,       1'b1},
      '{REQ_UNKNOWN,    7'h7F, 8'hFF, 8'hFF, 8'hFF, 1'b1, 8'd0,  20'd0,       1'b1},
      // command with all-zero and all-one fields, then two byte writes
      '{REQ_COMMAND,    7'h00, 8'h00, 8'h00, 8'h00, 1'b0, 8'd0,  20'd0,       1'b0},
      '{REQ_COMMAND,    7'h7F, 8'hFF, 8'hFF, 8'hFF, 1'b1, 8'd0,  20'd0,       1'b0},
      '{REQ_WRITE_BYTE, 7'h55, 8'h00, 8'hA5, 8'h01, 1'b0, 8'd0,  20'd0,       1'b0},
      '{REQ_WRITE_BYTE, 7'h2A, 8'hFF, 8'h5A, 8'h00, 1'b0, 8'd0,  20'd0,       1'b0},
      // block write of length zero sends the addresses only, then one of length three
      '{REQ_WRITE_BLK,  7'h50, 8'h10, 8'h3C, 8'h00, 1'b0, 8'd0,  20'd0,       1'b0},
      '{REQ_WRITE_BLK,  7'h50, 8'h11, 8'hC3, 8'h03, 1'b0, 8'd0,  20'd0,       1'b0},
      // byte read ignores its length, byte and block reads ignore stretch enable
      '{REQ_READ_BYTE,  7'h7F, 8'h80, 8'h00, 8'hC8, 1'b1, 8'd6,  20'd0,       1'b0},
      '{REQ_READ_BLK,   7'h00, 8'h00, 8'h00, 8'h00, 1'b0, 8'd0,  20'd0,       1'b0},
      '{REQ_READ_BLK,   7'h21, 8'h40, 8'h00, 8'h04, 1'b1, 8'd8,  20'd0,       1'b0},
      // current-address reads, without and with stretch waits
      '{REQ_READ_CUR,   7'h68, 8'h00, 8'h00, 8'h02, 1'b0, 8'd0,  20'd0,       1'b0},
      '{REQ_READ_CUR,   7'h68, 8'h00, 8'h00, 8'h03, 1'b1, 8'd5,  20'd0,       1'b0},
      '{REQ_READ_CUR,   7'h68, 8'h33, 8'h00, 8'h00, 1'b1, 8'd0,  20'd0,       1'b0},
      // timeout expiring at the smallest and a small setting, then the largest
      '{REQ_READ_CUR,   7'h01, 8'h00, 8'h00, 8'h02, 1'b1, 8'd10, 20'd1,       1'b0},
      '{REQ_READ_CUR,   7'h3C, 8'h00, 8'h00, 8'h00, 1'b1, 8'd20, 20'd5,       1'b0},
      '{REQ_READ_CUR,   7'h7E, 8'h00, 8'h00, 8'h02, 1'b1, 8'd30, 20'hFFFFF,   1'b0},
      '{REQ_NONE,       7'h00, 8'h00, 8'h00, 8'h00, 1'b0, 8'd0,  20'd0,       1'b1}
   };

   logic                   clock;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata = '0;
   logic [2:0]             req_tuser = REQ_NONE;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic                   rsp_tlast;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [TIMEOUT_W-1:0]   csr_data = '0;

   // predicted sequencer state
   phase_type            seq_phase     = PH_IDLE;
   logic [2:0]           phase_ticks   = '0;
   logic [3:0]           bits_done     = '0;
   logic [7:0]           shifter       = '0;
   logic [7:0]           bytes_done    = '0;
   logic [2:0]           held_kind     = '0;
   logic [6:0]           held_dev      = '0;
   logic [7:0]           held_word     = '0;
   logic [7:0]           held_len      = '0;
   logic                 held_stretch  = 1'b0;
   logic [COUNT_W-1:0]   wait_count    = '0;
   logic [1:0]           line_drive    = 2'b11;   // scl, sda
   logic [TIMEOUT_W-1:0] stretch_limit = TIMEOUT_RESET;

   tick_result_type pending_results [$];
   int              mismatch_count = 0;
   int              ticks_sent     = 0;
   int              idle_pct       = 0;
   int              stall_pct      = 0;
   int              scl_low_plan   = 0;
   int              scl_low_left   = 0;
   bit              hold_start     = 1'b0;
   int              hold_left      = 0;

   i2c_master_transaction_sequencer #(
      .STRETCH_COUNT_BITS (COUNT_W)
   ) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   // 20 ns clock
   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   // ---------------------------------------------------------------------
   // tick predictor
   // ---------------------------------------------------------------------

   function automatic void enter_phase(phase_type p);
      seq_phase   = p;
      phase_ticks = '0;
      bits_done   = '0;
   endfunction

   // a byte read and a zero length both read exactly one byte
   function automatic logic [7:0] bytes_to_read();
      if (held_kind == REQ_READ_BYTE || held_len == 8'd0) return 8'd1;
      return held_len;
   endfunction

   function automatic phase_type read_entry();
      return held_stretch ? PH_RX_PRE : PH_RX_BITS;
   endfunction

   // where the sequencer goes once a sent byte and its acknowledge are over
   function automatic phase_type after_sent_byte();
      case (seq_phase)
         PH_ADDRW: return (held_kind == REQ_COMMAND) ? PH_DATA : PH_WORD;
         PH_WORD: begin
            if (held_kind == REQ_WRITE_BYTE) return PH_DATA;
            if (held_kind == REQ_WRITE_BLK) return (held_len != 8'd0) ? PH_DATA : PH_STOP;
            return PH_START_R;
         end
         PH_DATA: begin
            if (held_kind == REQ_WRITE_BLK) begin
               bytes_done = bytes_done + 8'd1;
               return (bytes_done < held_len) ? PH_DATA : PH_STOP;
            end
            return PH_STOP;
         end
         default: return read_entry();
      endcase
   endfunction

   function automatic tick_result_type predict_bus_tick(tick_req_type r);
      tick_result_type o;
      logic [2:0]      t;
      o = IDLE_TICK;
      // a request is only taken when nothing is running
      if (seq_phase == PH_IDLE && r.kind >= REQ_COMMAND && r.kind <= REQ_READ_CUR) begin
         held_kind    = r.kind;
         held_dev     = r.dev;
         held_word    = r.word;
         held_len     = r.len;
         held_stretch = (r.kind == REQ_READ_CUR) ? r.stretch : 1'b0;
         bytes_done   = '0;
         enter_phase((r.kind == REQ_READ_CUR) ? PH_START_R : PH_START_W);
      end
      t = phase_ticks;
      o.busy = (seq_phase != PH_IDLE);
      case (seq_phase)
         PH_START_W, PH_START_R: begin
            if (t < 3'd2) begin
               o.scl = line_drive[1];
            end else if (t < 3'd4) begin
               o.scl = 1'b1;
            end else if (t < 3'd6) begin
               o.sda = 1'b0;
            end else begin
               o.scl = 1'b0;
               o.sda = 1'b0;
            end
            if (t >= 3'd7) enter_phase((seq_phase == PH_START_W) ? PH_ADDRW : PH_ADDRR);
            else phase_ticks++;
         end
         PH_ADDRW, PH_WORD, PH_DATA, PH_ADDRR: begin
            if (bits_done < 4'd8) begin
               if (bits_done == 4'd0 && t == 3'd0) begin
                  case (seq_phase)
                     PH_ADDRW: shifter = {held_dev, 1'b0};
                     PH_WORD:  shifter = held_word;
                     PH_DATA: begin
                        shifter = r.txb;
                        o.taken = 1'b1;
                     end
                     default:  shifter = {held_dev, 1'b1};
                  endcase
               end
               o.sda = shifter[7];
               o.scl = (t == 3'd1 || t == 3'd2);
               if (t >= 3'd3) begin
                  shifter     = {shifter[6:0], 1'b0};
                  phase_ticks = '0;
                  bits_done++;
               end else begin
                  phase_ticks++;
               end
            end else begin
               // tail tick, then the slave acknowledge that nobody looks at
               if (t == 3'd0) begin
                  o.scl = 1'b0;
                  o.sda = line_drive[0];
               end else begin
                  o.scl = (t == 3'd3 || t == 3'd4);
               end
               if (t >= 3'd6) enter_phase(after_sent_byte());
               else phase_ticks++;
            end
         end
         PH_RX_PRE: begin
            if (t >= 3'd1) begin
               wait_count = '0;
               enter_phase(PH_RX_WAIT);
            end else begin
               phase_ticks++;
            end
         end
         PH_RX_WAIT: begin
            if (r.scl_in || wait_count >= stretch_limit) enter_phase(PH_RX_POST);
            else if (wait_count != '1) wait_count++;
         end
         PH_RX_POST: begin
            if (t >= 3'd1) enter_phase(PH_RX_BITS);
            else phase_ticks++;
         end
         PH_RX_BITS: begin
            o.scl = (t < 3'd2);
            if (t == 3'd1) begin
               shifter = {shifter[6:0], r.sda_in};
               if (bits_done >= 4'd7) begin
                  o.rx_valid = 1'b1;
                  o.rx_byte  = shifter;
                  o.rx_last  = ({1'b0, bytes_done} + 9'd1) >= {1'b0, bytes_to_read()};
               end
            end
            if (t >= 3'd3) begin
               if (bits_done >= 4'd7) begin
                  bytes_done = bytes_done + 8'd1;
                  enter_phase((bytes_done >= bytes_to_read()) ? PH_MNACK : PH_MACK);
               end else begin
                  bits_done++;
                  phase_ticks = '0;
               end
            end else begin
               phase_ticks++;
            end
         end
         PH_MACK: begin
            if (t < 3'd6) begin
               o.sda = 1'b0;
               o.scl = (t == 3'd2 || t == 3'd3);
            end else begin
               o.scl = 1'b0;
            end
            if (t >= 3'd6) enter_phase(read_entry());
            else phase_ticks++;
         end
         PH_MNACK: begin
            o.scl = (t == 3'd2 || t == 3'd3);
            if (t >= 3'd5) enter_phase(PH_STOP);
            else phase_ticks++;
         end
         PH_STOP: begin
            if (t < 3'd2) begin
               o.scl = 1'b0;
               o.sda = 1'b0;
            end else if (t < 3'd4) begin
               o.sda = 1'b0;
            end
            if (t >= 3'd5) begin
               o.done = 1'b1;
               enter_phase(PH_IDLE);
            end else begin
               phase_ticks++;
            end
         end
         default: begin
            if (seq_phase != PH_IDLE) enter_phase(PH_IDLE);
            o.busy = 1'b0;
         end
      endcase
      line_drive = {o.scl, o.sda};
      return o;
   endfunction

   // ---------------------------------------------------------------------
   // stimulus helpers
   // ---------------------------------------------------------------------

   function automatic logic [REQ_TDATA_W-1:0] req_beat(tick_req_type r);
      logic [REQ_TDATA_W-1:0] d;
      d = '0;
      d[REQ_DEV_LSB +: 7]  = r.dev;
      d[REQ_WORD_LSB +: 8] = r.word;
      d[REQ_TX_LSB +: 8]   = r.txb;
      d[REQ_LEN_LSB +: 8]  = r.len;
      d[REQ_STRETCH_BIT]   = r.stretch;
      d[REQ_SDA_BIT]       = r.sda_in;
      d[REQ_SCL_BIT]       = r.scl_in;
      return d;
   endfunction

   function automatic tick_req_type random_tick();
      tick_req_type r;
      r.kind    = 3'($urandom_range(0, 7));
      r.dev     = 7'($urandom);
      r.word    = 8'($urandom);
      r.txb     = 8'($urandom);
      r.len     = 8'($urandom);
      r.stretch = 1'($urandom);
      r.sda_in  = 1'($urandom);
      r.scl_in  = 1'($urandom);
      return r;
   endfunction

   // slave side of the lines: random data, scl held low for a while on each stretch wait
   function automatic tick_req_type with_lines(tick_req_type r);
      r.sda_in = 1'($urandom);
      if (seq_phase == PH_RX_PRE) scl_low_left = scl_low_plan;
      if (seq_phase == PH_RX_WAIT) begin
         r.scl_in = (scl_low_left == 0);
         if (scl_low_left != 0) scl_low_left--;
      end else begin
         r.scl_in = 1'($urandom);
      end
      return r;
   endfunction

   // offer one tick, predict it once it is taken; starts and ends just after a falling edge
   task automatic send_tick(input tick_req_type r, input bit fixed_idle);
      tick_result_type want;
      while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= r.kind;
      req_tdata  <= req_beat(r);
      do @(posedge clock); while (!req_tready);
      want = predict_bus_tick(r);
      pending_results.push_back(fixed_idle ? IDLE_TICK : want);
      ticks_sent++;
      @(negedge clock);
   endtask

   // first tick carries the request, then ticks go on until the sequencer is idle again;
   // with scramble set the busy ticks carry random fields and request codes
   task automatic run_transaction(input tick_req_type r, input int scl_low, input bit scramble,
                                  input bit fixed_idle);
      scl_low_plan = scl_low;
      send_tick(with_lines(r), fixed_idle);
      while (seq_phase != PH_IDLE) begin
         if (scramble) r = random_tick();
         send_tick(with_lines(r), 1'b0);
      end
   endtask

   // stop offering and let every outstanding beat come back
   task automatic settle();
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(negedge clock);
   endtask

   task automatic write_timeout(input logic [TIMEOUT_W-1:0] value);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      stretch_limit = value;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // ---------------------------------------------------------------------
   // response side: random stalls, plus one long hold-off to back the block up
   // ---------------------------------------------------------------------

   always @(negedge clock) begin
      if (hold_start) begin
         hold_start = 1'b0;
         hold_left  = 300;
      end
      if (hold_left != 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= stall_pct);
      end
   end

   function automatic string show(tick_result_type v);
      return $sformatf("scl %b sda %b busy %b rx %h valid %b last %b taken %b done %b",
                       v.scl, v.sda, v.busy, v.rx_byte, v.rx_valid, v.rx_last, v.taken, v.done);
   endfunction

   // compare every response beat with the oldest prediction
   always @(posedge clock) begin
      tick_result_type got;
      tick_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.scl      = rsp_tdata[RSP_SCL_BIT];
         got.sda      = rsp_tdata[RSP_SDA_BIT];
         got.busy     = rsp_tdata[RSP_BUSY_BIT];
         got.rx_byte  = rsp_tdata[RSP_RXB_LSB +: 8];
         got.rx_valid = rsp_tdata[RSP_RXV_BIT];
         got.rx_last  = rsp_tlast;
         got.taken    = rsp_tdata[RSP_TAKEN_BIT];
         got.done     = rsp_tdata[RSP_DONE_BIT];
         if (pending_results.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10) $display("tb: beat with nothing pending: %s", show(got));
         end else begin
            want = pending_results.pop_front();
            if (got !== want) begin
               mismatch_count++;
               if (mismatch_count <= 10) begin
                  $display("tb: mismatch at %0t", $realtime);
                  $display("   expected %s", show(want));
                  $display("   actual   %s", show(got));
               end
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // main sequence
   // ---------------------------------------------------------------------

   initial begin : stimulus
      tick_req_type         r;
      script_row_type       row;
      int                   phase_end;
      int                   low;
      logic [TIMEOUT_W-1:0] limit;

      // reset is held from the start and released on a falling edge
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed script, block fully idle between rows
      for (int i = 0; i < SCRIPT_LEN; i++) begin
         row = SCRIPT[i];
         if (row.timeout_wr != '0) begin
            settle();
            write_timeout(row.timeout_wr);
         end
         r.kind    = row.kind;
         r.dev     = row.dev;
         r.word    = row.word;
         r.txb     = row.txb;
         r.len     = row.len;
         r.stretch = row.stretch;
         r.sda_in  = 1'b0;
         r.scl_in  = 1'b0;
         run_transaction(r, int'(row.scl_low), 1'b0, row.fixed_idle);
      end

      // random transactions in four idling regimes, each with its own timeout
      for (int p = 0; p < 4; p++) begin
         settle();
         case (p)
            0:       limit = TIMEOUT_W'($urandom_range(2, 40));
            1:       limit = '1;
            2:       limit = TIMEOUT_W'(1);
            default: limit = TIMEOUT_W'($urandom_range(41, 5000));
         endcase
         write_timeout(limit);
         idle_pct  = (p == 1) ? 64 : (p == 3) ? 27 : 0;
         stall_pct = (p == 2) ? 64 : (p == 3) ? 27 : 0;
         if (p == 0) hold_start = 1'b1;
         phase_end = ticks_sent + 100;
         while (ticks_sent < phase_end) begin
            // a few ignored ticks between transactions, sometimes none
            repeat ($urandom_range(0, 3)) begin
               r      = random_tick();
               r.kind = ($urandom_range(1) != 0) ? REQ_UNKNOWN : REQ_NONE;
               run_transaction(r, 0, 1'b1, 1'b0);
            end
            r      = random_tick();
            r.kind = 3'($urandom_range(REQ_COMMAND, REQ_READ_CUR));
            r.len  = ($urandom_range(19) == 0) ? 8'($urandom_range(0, 16))
                                              : 8'($urandom_range(0, 3));
            low    = (stretch_limit <= 64) ? $urandom_range(0, int'(stretch_limit) + 3)
                                           : $urandom_range(0, 12);
            run_transaction(r, low, 1'b1, 1'b0);
         end
      end

      settle();
      repeat (8) @(negedge clock);
      if (mismatch_count == 0 && pending_results.size() == 0) begin
         $display("tb: done, clean");
      end else begin
         $display("tb: done, errors");
      end
      $finish;
   end

   // the slowest correct run is a small fraction of this
   initial begin : watchdog
      #10ms;
      $display("tb: done, errors");
      $finish;
   end

endmodule
